FILE: hdl/mlpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlpq_pkg: shared types and constants of the multilevel priority queue.
// Holds operation and status codes, the controller state and command types.
// ----------------------------------------------------------------------------
package mlpq_pkg;

    localparam int NumSlotsDefault  = 16;
    localparam int NumLevelsDefault = 4;
    localparam int NumQuantum       = 3;
    localparam int QuantumW         = 16;
    localparam int CfgIdxW          = 2;

    localparam logic [1:0] MODE_PUSH   = 2'd0;
    localparam logic [1:0] MODE_POP    = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_BADSLOT = 2'd3;

    localparam logic [CfgIdxW-1:0] CFG_Q1 = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_Q2 = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_Q3 = 2'd2;

    localparam logic [QuantumW-1:0] Q1_RESET = 16'd3;
    localparam logic [QuantumW-1:0] Q2_RESET = 16'd2;
    localparam logic [QuantumW-1:0] Q3_RESET = 16'd1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic exec;
    } cmd_t;

    typedef struct packed {
        logic done;
    } sts_t;

endpackage

FILE: hdl/mlpq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlpq_ctrl: operation sequencer.
// Takes one word, lets the datapath execute it, then holds the result word.
// ----------------------------------------------------------------------------
module mlpq_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    output mlpq_pkg::cmd_t  cmd
);

    mlpq_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mlpq_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        cmd.start  = 1'b0;
        cmd.exec   = 1'b0;
        unique case (state_reg)
            mlpq_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    state_next = mlpq_pkg::S_EXEC;
                end
            end
            mlpq_pkg::S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = mlpq_pkg::S_OUT;
            end
            mlpq_pkg::S_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = mlpq_pkg::S_IDLE;
                end
            end
            default: state_next = mlpq_pkg::S_IDLE;
        endcase
    end

endmodule

FILE: hdl/mlpq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlpq_datapath: slot pool, linked level lists and result register.
// Executes one push, pop or remove in the cycle the controller orders.
// ----------------------------------------------------------------------------
module mlpq_datapath #(
    parameter int NUM_SLOTS  = mlpq_pkg::NumSlotsDefault,
    parameter int NUM_LEVELS = mlpq_pkg::NumLevelsDefault,
    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1,
    localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1,
    localparam int CW = $clog2(NUM_SLOTS + 1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mlpq_pkg::cmd_t                cmd,
    input  logic [1:0]                    s_mode,
    input  logic [15:0]                   s_proc_id,
    input  logic [15:0]                   s_run_time,
    input  logic [1:0]                    s_level,
    input  logic [3:0]                    s_slot_in,
    input  logic                          cfg_we,
    input  logic [mlpq_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [15:0]                   cfg_data,
    output logic [1:0]                    m_status,
    output logic [15:0]                   m_proc_id_out,
    output logic [15:0]                   m_run_time_out,
    output logic [1:0]                    m_level_out,
    output logic [15:0]                   m_quantum_out,
    output logic [3:0]                    m_slot_out,
    output logic [4:0]                    m_waiting_total
);

    logic [15:0]   pid_mem [NUM_SLOTS];
    logic [15:0]   rt_mem  [NUM_SLOTS];
    logic [LW-1:0] lv_mem  [NUM_SLOTS];
    logic [15:0]   q_mem   [NUM_SLOTS];
    logic [SW-1:0] newer_mem [NUM_SLOTS];
    logic [SW-1:0] older_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] used_reg;
    logic [SW-1:0] oldest_reg [NUM_LEVELS];
    logic [SW-1:0] newest_reg [NUM_LEVELS];
    logic [CW-1:0] lcount_reg [NUM_LEVELS];
    logic [CW-1:0] total_reg;
    logic [15:0]   quant_reg [mlpq_pkg::NumQuantum];

    // Input word latched at acceptance.
    logic [1:0]  mode_reg;
    logic [15:0] pid_reg, rt_reg;
    logic [1:0]  lvin_reg;
    logic [3:0]  sin_reg;

    logic [1:0]  status_reg;
    logic [15:0] opid_reg, ort_reg, oq_reg;
    logic [1:0]  olv_reg;
    logic [3:0]  oslot_reg;

    // Lowest free slot and highest-priority nonempty level.
    logic          free_found;
    logic [SW-1:0] free_slot;
    logic          lvl_found;
    logic [LW-1:0] pop_lvl;
    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (!used_reg[i]) begin
                free_found = 1'b1;
                free_slot  = SW'(i);
            end
        end
        lvl_found = 1'b0;
        pop_lvl   = '0;
        for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
            if (lcount_reg[l] != '0) begin
                lvl_found = 1'b1;
                pop_lvl   = LW'(l);
            end
        end
    end

    logic [LW-1:0] push_lvl;
    logic          rm_ok;
    logic [SW-1:0] rm_slot;
    always_comb begin
        if (32'(lvin_reg) >= NUM_LEVELS) push_lvl = LW'(NUM_LEVELS - 1);
        else                             push_lvl = LW'(lvin_reg);
        rm_ok   = (32'(sin_reg) < NUM_SLOTS) && used_reg[SW'(sin_reg)];
        rm_slot = SW'(sin_reg);
    end

    // Slot being unlinked by pop or remove.
    logic [SW-1:0] un_s;
    logic [LW-1:0] un_l;
    logic          is_old, is_new;
    always_comb begin
        un_s   = (mode_reg == mlpq_pkg::MODE_POP) ? oldest_reg[pop_lvl] : rm_slot;
        un_l   = lv_mem[un_s];
        is_old = (oldest_reg[un_l] == un_s);
        is_new = (newest_reg[un_l] == un_s);
    end

    logic do_push, do_unlink;
    always_comb begin
        do_push   = cmd.exec && (mode_reg == mlpq_pkg::MODE_PUSH) && free_found;
        do_unlink = cmd.exec && (((mode_reg == mlpq_pkg::MODE_POP) && lvl_found)
                    || ((mode_reg == mlpq_pkg::MODE_REMOVE) && rm_ok));
    end

    logic [15:0] push_q;
    int          q_idx;
    always_comb begin
        q_idx = int'(push_lvl) - 1;
        // Levels past the last quantum register wrap around to the first ones.
        for (int k = 0; k < 2; k++) begin
            if (q_idx >= mlpq_pkg::NumQuantum) q_idx = q_idx - mlpq_pkg::NumQuantum;
        end
        if (push_lvl == '0) push_q = rt_reg;
        else                push_q = quant_reg[2'(q_idx)];
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            mode_reg <= s_mode;
            pid_reg  <= s_proc_id;
            rt_reg   <= s_run_time;
            lvin_reg <= s_level;
            sin_reg  <= s_slot_in;
        end
        if (do_push) begin
            pid_mem[free_slot] <= pid_reg;
            rt_mem[free_slot]  <= rt_reg;
            lv_mem[free_slot]  <= push_lvl;
            q_mem[free_slot]   <= push_q;
            if (lcount_reg[push_lvl] == '0) begin
                oldest_reg[push_lvl] <= free_slot;
            end else begin
                newer_mem[newest_reg[push_lvl]] <= free_slot;
                older_mem[free_slot] <= newest_reg[push_lvl];
            end
            newest_reg[push_lvl] <= free_slot;
        end
        if (do_unlink) begin
            if (is_old && !is_new) begin
                oldest_reg[un_l] <= newer_mem[un_s];
            end else if (is_new && !is_old) begin
                newest_reg[un_l] <= older_mem[un_s];
            end else if (!is_old && !is_new) begin
                newer_mem[older_mem[un_s]] <= newer_mem[un_s];
                older_mem[newer_mem[un_s]] <= older_mem[un_s];
            end
        end
        if (cmd.exec) begin
            status_reg <= mlpq_pkg::ST_OK;
            opid_reg   <= '0;
            ort_reg    <= '0;
            olv_reg    <= '0;
            oq_reg     <= '0;
            oslot_reg  <= '0;
            case (mode_reg)
                mlpq_pkg::MODE_PUSH: begin
                    if (free_found) begin
                        opid_reg  <= pid_reg;
                        ort_reg   <= rt_reg;
                        olv_reg   <= 2'(push_lvl);
                        oq_reg    <= push_q;
                        oslot_reg <= 4'(free_slot);
                    end else begin
                        status_reg <= mlpq_pkg::ST_FULL;
                        opid_reg   <= pid_reg;
                        ort_reg    <= rt_reg;
                        olv_reg    <= lvin_reg;
                    end
                end
                mlpq_pkg::MODE_POP, mlpq_pkg::MODE_REMOVE: begin
                    if (do_unlink) begin
                        opid_reg  <= pid_mem[un_s];
                        ort_reg   <= rt_mem[un_s];
                        olv_reg   <= 2'(un_l);
                        oq_reg    <= q_mem[un_s];
                        oslot_reg <= 4'(un_s);
                    end else if (mode_reg == mlpq_pkg::MODE_POP) begin
                        status_reg <= mlpq_pkg::ST_EMPTY;
                    end else begin
                        status_reg <= mlpq_pkg::ST_BADSLOT;
                        oslot_reg  <= sin_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg  <= '0;
            total_reg <= '0;
            for (int l = 0; l < NUM_LEVELS; l++) lcount_reg[l] <= '0;
            quant_reg[0] <= mlpq_pkg::Q1_RESET;
            quant_reg[1] <= mlpq_pkg::Q2_RESET;
            quant_reg[2] <= mlpq_pkg::Q3_RESET;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    mlpq_pkg::CFG_Q1: quant_reg[0] <= cfg_data;
                    mlpq_pkg::CFG_Q2: quant_reg[1] <= cfg_data;
                    mlpq_pkg::CFG_Q3: quant_reg[2] <= cfg_data;
                    default: ;
                endcase
            end
            if (do_push) begin
                used_reg[free_slot]  <= 1'b1;
                lcount_reg[push_lvl] <= lcount_reg[push_lvl] + 1'b1;
                total_reg            <= total_reg + 1'b1;
            end
            if (do_unlink) begin
                used_reg[un_s] <= 1'b0;
                if (lcount_reg[un_l] != '0) lcount_reg[un_l] <= lcount_reg[un_l] - 1'b1;
                if (total_reg != '0) total_reg <= total_reg - 1'b1;
            end
        end
    end

    assign m_status        = status_reg;
    assign m_proc_id_out   = opid_reg;
    assign m_run_time_out  = ort_reg;
    assign m_level_out     = olv_reg;
    assign m_quantum_out   = oq_reg;
    assign m_slot_out      = oslot_reg;
    assign m_waiting_total = 5'(total_reg);

endmodule

FILE: hdl/multilevel_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multilevel_priority_queue: four FIFO levels over one shared slot pool.
// Each input word is a push, pop or remove; each yields one result word.
// Channels: s_* carries the operation word and m_* the result word, both with
// valid/ready. The user is to write the three level quanta over the cfg_* port
// only at an idle time; the block itself does not enforce this. An accepted
// word is latched into the input registers and executed into the result
// registers; the block then holds it until taken. One word is in flight at a
// time; each goes through the sequencer's accept, execute and deliver steps.
// When the receiver stalls, the result stays registered and s_ready is low.
// Reset clears all slot-in-use flags, level counts and the total count, and
// loads the quanta with 3, 2 and 1; it needs no clearing pass.
// ----------------------------------------------------------------------------
module multilevel_priority_queue #(
    parameter int NUM_SLOTS  = mlpq_pkg::NumSlotsDefault,
    parameter int NUM_LEVELS = mlpq_pkg::NumLevelsDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [15:0] s_proc_id,
    input  logic [15:0] s_run_time,
    input  logic [1:0]  s_level,
    input  logic [3:0]  s_slot_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [15:0] m_proc_id_out,
    output logic [15:0] m_run_time_out,
    output logic [1:0]  m_level_out,
    output logic [15:0] m_quantum_out,
    output logic [3:0]  m_slot_out,
    output logic [4:0]  m_waiting_total,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    mlpq_pkg::cmd_t cmd;

    mlpq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    mlpq_datapath #(
        .NUM_SLOTS  (NUM_SLOTS),
        .NUM_LEVELS (NUM_LEVELS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .s_mode          (s_mode),
        .s_proc_id       (s_proc_id),
        .s_run_time      (s_run_time),
        .s_level         (s_level),
        .s_slot_in       (s_slot_in),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .m_status        (m_status),
        .m_proc_id_out   (m_proc_id_out),
        .m_run_time_out  (m_run_time_out),
        .m_level_out     (m_level_out),
        .m_quantum_out   (m_quantum_out),
        .m_slot_out      (m_slot_out),
        .m_waiting_total (m_waiting_total)
    );

endmodule
